// ----- design/fct_pkg.sv -----
// fct_pkg: shared constants, plane table and link type for the frustum cull test
// depends on nothing; used by every module of the block

package fct_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int COEFF_WIDTH = 16;
  localparam int COORD_FRAC  = 8;
  localparam int NUM_PLANES  = 6;
  localparam int NUM_COLS    = 4;
  localparam int NUM_AXES    = 3;
  localparam int CFG_WIDTH   = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int W_ROW       = 3;

  typedef enum logic {
    MODE_BOX    = 1'b0,
    MODE_SPHERE = 1'b1
  } mode_e;

  // near, far, bottom, top, left, right
  localparam int PLANE_ROW [NUM_PLANES] = '{2, 2, 1, 1, 0, 0};
  localparam bit PLANE_NEG [NUM_PLANES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

  typedef struct packed {
    logic valid;
    logic visible;
  } link_t;

endpackage

// ----- design/fct_bound.sv -----
// fct_bound: input stage, box corners as given or sphere to min/max corners
// depends on fct_pkg

module fct_bound #(
  parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH,
  parameter int DATA_W      = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  logic [DATA_W-1:0]                  data_i,
  input  logic                               mode_i,
  output fct_pkg::link_t                     link_o,
  input  logic                               ready_i,
  output logic [fct_pkg::NUM_AXES-1:0][COORD_WIDTH:0] lo_o,
  output logic [fct_pkg::NUM_AXES-1:0][COORD_WIDTH:0] hi_o
);

  localparam int CO = COORD_WIDTH + 1;

  logic                                 valid_q;
  logic [fct_pkg::NUM_AXES-1:0][CO-1:0] lo_q, lo_d;
  logic [fct_pkg::NUM_AXES-1:0][CO-1:0] hi_q, hi_d;
  logic [CO-1:0]                        rad;

  assign ready_o = !valid_q || ready_i;
  assign rad = {2'b00, data_i[2*fct_pkg::NUM_AXES*COORD_WIDTH +: COORD_WIDTH-1]};

  always_comb begin
    logic signed [CO-1:0] pos;
    logic signed [CO-1:0] fa;
    for (int a = 0; a < fct_pkg::NUM_AXES; a++) begin
      pos = $signed({data_i[a*COORD_WIDTH+COORD_WIDTH-1],
                     data_i[a*COORD_WIDTH +: COORD_WIDTH]});
      fa  = $signed({data_i[(a+3)*COORD_WIDTH+COORD_WIDTH-1],
                     data_i[(a+3)*COORD_WIDTH +: COORD_WIDTH]});
      if (fct_pkg::mode_e'(mode_i) == fct_pkg::MODE_SPHERE) begin
        lo_d[a] = pos - $signed(rad);
        hi_d[a] = pos + $signed(rad);
      end else begin
        lo_d[a] = pos;
        hi_d[a] = fa;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

  assign link_o.valid   = valid_q;
  assign link_o.visible = 1'b1;
  assign lo_o = lo_q;
  assign hi_o = hi_q;

endmodule

// ----- design/fct_plane_cell.sv -----
// fct_plane_cell: one plane of the chain, holds its coefficients and tests the
// farthest corner in a multiply stage and a sum stage; depends on fct_pkg

module fct_plane_cell #(
  parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH,
  parameter int COEFF_WIDTH = fct_pkg::COEFF_WIDTH,
  parameter int PLANE       = 0
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          load_i,
  input  logic [fct_pkg::NUM_COLS-1:0][fct_pkg::CFG_WIDTH-1:0] mat_i,
  input  fct_pkg::link_t                                link_i,
  output logic                                          ready_o,
  input  logic [fct_pkg::NUM_AXES-1:0][COORD_WIDTH:0]   lo_i,
  input  logic [fct_pkg::NUM_AXES-1:0][COORD_WIDTH:0]   hi_i,
  output fct_pkg::link_t                                link_o,
  input  logic                                          ready_i,
  output logic [fct_pkg::NUM_AXES-1:0][COORD_WIDTH:0]   lo_o,
  output logic [fct_pkg::NUM_AXES-1:0][COORD_WIDTH:0]   hi_o
);

  localparam int CO    = COORD_WIDTH + 1;
  localparam int CE    = COEFF_WIDTH + 1;
  localparam int PW    = CE + CO;
  localparam int SW    = PW + 2;
  localparam int EXT_W = fct_pkg::NUM_COLS * COEFF_WIDTH + fct_pkg::CFG_WIDTH;
  localparam int ROW   = fct_pkg::PLANE_ROW[PLANE];
  localparam bit NEG   = fct_pkg::PLANE_NEG[PLANE];

  logic [fct_pkg::NUM_COLS-1:0][CE-1:0] coeff_q, coeff_d;

  logic                                 p_valid_q, p_vis_q, p_ready;
  logic [fct_pkg::NUM_AXES-1:0][CO-1:0] p_lo_q, p_hi_q;
  logic [fct_pkg::NUM_AXES-1:0][PW-1:0] prod_q, prod_d;
  logic [PW-1:0]                        dterm_q, dterm_d;

  logic                                 s_valid_q, s_vis_q, s_ready;
  logic [fct_pkg::NUM_AXES-1:0][CO-1:0] s_lo_q, s_hi_q;
  logic signed [SW-1:0]                 sum;

  function automatic logic [COEFF_WIDTH-1:0] entry(logic [fct_pkg::CFG_WIDTH-1:0] col,
                                                   int row);
    logic [EXT_W-1:0] ext;
    ext = {{(fct_pkg::NUM_COLS*COEFF_WIDTH){1'b0}}, col};
    return ext[row*COEFF_WIDTH +: COEFF_WIDTH];
  endfunction

  always_comb begin
    logic [COEFF_WIDTH-1:0] w;
    logic [COEFF_WIDTH-1:0] e;
    for (int j = 0; j < fct_pkg::NUM_COLS; j++) begin
      w = entry(mat_i[j], fct_pkg::W_ROW);
      e = entry(mat_i[j], ROW);
      if (NEG) begin
        coeff_d[j] = $signed({w[COEFF_WIDTH-1], w}) - $signed({e[COEFF_WIDTH-1], e});
      end else begin
        coeff_d[j] = $signed({w[COEFF_WIDTH-1], w}) + $signed({e[COEFF_WIDTH-1], e});
      end
    end
  end

  // farthest corner along the normal, then one product per axis
  always_comb begin
    logic signed [CE-1:0] n;
    logic signed [CO-1:0] c;
    for (int a = 0; a < fct_pkg::NUM_AXES; a++) begin
      n = $signed(coeff_q[a]);
      c = n[CE-1] ? $signed(lo_i[a]) : $signed(hi_i[a]);
      prod_d[a] = PW'(n * c);
    end
    dterm_d = PW'($signed(coeff_q[fct_pkg::NUM_COLS-1])) <<< fct_pkg::COORD_FRAC;
  end

  assign sum = SW'($signed(prod_q[0])) + SW'($signed(prod_q[1]))
             + SW'($signed(prod_q[2])) + SW'($signed(dterm_q));

  assign s_ready = !s_valid_q || ready_i;
  assign p_ready = !p_valid_q || s_ready;
  assign ready_o = p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q   <= '0;
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        coeff_q <= coeff_d;
      end
      if (p_ready) begin
        p_valid_q <= link_i.valid;
      end
      if (s_ready) begin
        s_valid_q <= p_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_ready && link_i.valid) begin
      prod_q  <= prod_d;
      dterm_q <= dterm_d;
      p_vis_q <= link_i.visible;
      p_lo_q  <= lo_i;
      p_hi_q  <= hi_i;
    end
    if (s_ready && p_valid_q) begin
      s_vis_q <= p_vis_q && !sum[SW-1];
      s_lo_q  <= p_lo_q;
      s_hi_q  <= p_hi_q;
    end
  end

  assign link_o.valid   = s_valid_q;
  assign link_o.visible = s_vis_q;
  assign lo_o = s_lo_q;
  assign hi_o = s_hi_q;

endmodule

// ----- design/frustum_cull_test.sv -----
// frustum_cull_test: top level, matrix registers, input stage and six plane cells
// depends on fct_pkg, fct_bound, fct_plane_cell
//
// usage:
//   cfg_we_i / cfg_idx_i / cfg_wdata_i write one matrix column per cycle, no wait;
//   the six plane coefficient sets are rebuilt in the cycle after each write,
//   so writes go in while no volume is in flight
//   the s_axis channel takes one volume per transfer (tuser = box or sphere),
//   the m_axis channel returns one visible flag per volume, in order
//   throughput: one volume per cycle while m_axis_tready_i is high, set by the
//   chain of plane cells, each of which multiplies in one stage and sums and tests
//   in the next; the bound stage loads on the transfer, then two stages in each of
//   the six cells lead to m_axis_tvalid_o
//   stall: every stage has its own valid bit, so bubbles close up while the
//   receiver holds tready low and inputs are taken until all stages are full
//   reset: matrix and planes clear to zero (every volume visible), pipeline empty

module frustum_cull_test #(
  parameter int COORD_WIDTH = fct_pkg::COORD_WIDTH,
  parameter int COEFF_WIDTH = fct_pkg::COEFF_WIDTH
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [fct_pkg::CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [fct_pkg::CFG_WIDTH-1:0]             cfg_wdata_i,
  input  logic                                      s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // pos_x, pos_y, pos_z, far_x, far_y, far_z, radius, zero fill
  input  logic [((7*COORD_WIDTH-1+7)/8)*8-1:0]      s_axis_tdata_i,
  // mode
  input  logic                                      s_axis_tuser_i,
  output logic                                      m_axis_tvalid_o,
  input  logic                                      m_axis_tready_i,
  // visible, zero fill
  output logic [7:0]                                m_axis_tdata_o
);

  localparam int DATA_W = ((7*COORD_WIDTH-1+7)/8)*8;
  localparam int NP     = fct_pkg::NUM_PLANES;

  logic [fct_pkg::NUM_COLS-1:0][fct_pkg::CFG_WIDTH-1:0] mat_q;
  logic                                                 load_q;

  fct_pkg::link_t                                  link  [NP+1];
  logic                                            rdy   [NP+1];
  logic [fct_pkg::NUM_AXES-1:0][COORD_WIDTH:0]     lo    [NP+1];
  logic [fct_pkg::NUM_AXES-1:0][COORD_WIDTH:0]     hi    [NP+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q  <= '0;
      load_q <= 1'b0;
    end else begin
      load_q <= cfg_we_i;
      if (cfg_we_i) begin
        mat_q[cfg_idx_i] <= cfg_wdata_i;
      end
    end
  end

  fct_bound #(
    .COORD_WIDTH (COORD_WIDTH),
    .DATA_W      (DATA_W)
  ) u_bound (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .data_i  (s_axis_tdata_i),
    .mode_i  (s_axis_tuser_i),
    .link_o  (link[0]),
    .ready_i (rdy[0]),
    .lo_o    (lo[0]),
    .hi_o    (hi[0])
  );

  for (genvar k = 0; k < NP; k++) begin : g_cell
    fct_plane_cell #(
      .COORD_WIDTH (COORD_WIDTH),
      .COEFF_WIDTH (COEFF_WIDTH),
      .PLANE       (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .load_i  (load_q),
      .mat_i   (mat_q),
      .link_i  (link[k]),
      .ready_o (rdy[k]),
      .lo_i    (lo[k]),
      .hi_i    (hi[k]),
      .link_o  (link[k+1]),
      .ready_i (rdy[k+1]),
      .lo_o    (lo[k+1]),
      .hi_o    (hi[k+1])
    );
  end

  assign rdy[NP]         = m_axis_tready_i;
  assign m_axis_tvalid_o = link[NP].valid;
  assign m_axis_tdata_o  = {7'b0, link[NP].visible};

endmodule

// ----- tb/sv/tb_frustum_cull_test.sv -----
// tb_frustum_cull_test: self-checking bench for frustum_cull_test (box and sphere culling)
// depends on fct_pkg and the frustum_cull_test rtl; a scoreboard class predicts each flag
// from its own copy of the matrix, tasks drive both stream ports and the matrix write port

module tb_frustum_cull_test;
  import fct_pkg::*;

  localparam int TDATA_W      = ((7*COORD_WIDTH-1+7)/8)*8;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int LONG_HOLD    = 120;

  typedef enum logic [CFG_IDX_W-1:0] {
    MAT_COL0 = 2'd0,
    MAT_COL1 = 2'd1,
    MAT_COL2 = 2'd2,
    MAT_COL3 = 2'd3
  } mat_reg_e;

  typedef logic [3:0][CFG_WIDTH-1:0] matrix_t;

  typedef struct packed {
    mode_e                         mode;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] far_x;
    logic signed [COORD_WIDTH-1:0] far_y;
    logic signed [COORD_WIDTH-1:0] far_z;
    logic [COORD_WIDTH-2:0]        radius;
  } volume_t;

  localparam int VOL_W = $bits(volume_t);

  class cull_board;
    logic [CFG_WIDTH-1:0] column [4];
    longint               coeff [6][4];
    int                   plane_axis [6];
    bit                   plane_flip [6];
    bit                   flag_q [$];
    int                   errors;
    int                   boxes;
    int                   spheres;
    int                   shown;
    int                   culled;

    function new();
      plane_axis = '{2, 2, 1, 1, 0, 0};
      plane_flip = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      foreach (column[c]) column[c] = '0;
      foreach (coeff[k, j]) coeff[k][j] = 0;
      errors = 0; boxes = 0; spheres = 0; shown = 0; culled = 0;
    endfunction

    // planes are rebuilt from the whole matrix after every column write
    function void set_column(mat_reg_e idx, logic [CFG_WIDTH-1:0] val);
      longint w;
      longint e;
      column[idx] = val;
      for (int k = 0; k < 6; k++) begin
        for (int j = 0; j < 4; j++) begin
          w = longint'($signed(column[j][3*COEFF_WIDTH +: COEFF_WIDTH]));
          e = longint'($signed(column[j][plane_axis[k]*COEFF_WIDTH +: COEFF_WIDTH]));
          coeff[k][j] = plane_flip[k] ? (w - e) : (w + e);
        end
      end
    endfunction

    function bit predict_visible(volume_t v);
      longint lo [3];
      longint hi [3];
      longint ctr [3];
      longint rad;
      longint margin;
      longint n;
      ctr[0] = longint'(v.pos_x);
      ctr[1] = longint'(v.pos_y);
      ctr[2] = longint'(v.pos_z);
      rad = longint'({1'b0, v.radius});
      if (v.mode == MODE_SPHERE) begin
        for (int a = 0; a < 3; a++) begin
          lo[a] = ctr[a] - rad;
          hi[a] = ctr[a] + rad;
        end
      end else begin
        lo = ctr;
        hi[0] = longint'(v.far_x);
        hi[1] = longint'(v.far_y);
        hi[2] = longint'(v.far_z);
      end
      for (int k = 0; k < 6; k++) begin
        margin = coeff[k][3] * (longint'(1) << COORD_FRAC);
        for (int a = 0; a < 3; a++) begin
          n = coeff[k][a];
          margin += n * ((n >= 0) ? hi[a] : lo[a]);
        end
        if (margin < 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_volume(volume_t v);
      bit vis;
      vis = predict_visible(v);
      flag_q.push_back(vis);
      if (v.mode == MODE_SPHERE) spheres++; else boxes++;
      if (vis) shown++; else culled++;
    endfunction

    function void check_flag(bit got);
      bit want;
      if (flag_q.size() == 0) begin
        errors++;
        $display("%0t: visible flag with none expected, got %0b", $time, got);
        return;
      end
      want = flag_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: visible expected %0b got %0b", $time, want, got);
      end
    endfunction

    function int pending();
      return flag_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_WIDTH-1:0] cfg_wdata;
  logic                 s_valid;
  logic                 s_ready;
  logic [TDATA_W-1:0]   s_data;
  logic                 s_user;
  logic                 m_valid;
  logic                 m_ready;
  logic [7:0]           m_data;

  cull_board board = new();
  bit        send_eager;
  int        cycles;
  int        phases;

  frustum_cull_test i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d flags outstanding", cycles, board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, eager stretches, and two long hold-offs
  initial begin : result_side
    int  stall;
    int  taken;
    bit  eager;
    m_ready = 1'b0;
    taken   = 0;
    eager   = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 40 == 0) eager = ($urandom_range(0, 3) == 0);
      stall = eager ? 0 : $urandom_range(0, 19);
      if (taken == 250 || taken == 800) stall = LONG_HOLD;
      @(negedge clk_i);
      if (stall > 0) begin
        m_ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready = 1'b1;
      do @(posedge clk_i); while (!m_valid);
      board.check_flag(m_data[0]);
      taken++;
    end
  end

  task automatic send_volume(input volume_t v);
    int gap;
    gap = send_eager ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_user  = v.mode;
    s_data  = TDATA_W'({v.radius, v.far_z, v.far_y, v.far_x, v.pos_z, v.pos_y, v.pos_x});
    do @(posedge clk_i); while (!s_ready);
    board.note_volume(v);
  endtask

  task automatic wait_quiet();
    @(negedge clk_i);
    s_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // columns go in shuffled order; planes settle the cycle after the last write
  task automatic load_matrix(input matrix_t m);
    mat_reg_e order [4];
    mat_reg_e tmp;
    int       pick;
    order = '{MAT_COL0, MAT_COL1, MAT_COL2, MAT_COL3};
    for (int i = 3; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = order[i]; order[i] = order[pick]; order[pick] = tmp;
    end
    foreach (order[i]) begin
      @(negedge clk_i);
      cfg_we    = 1'b1;
      cfg_idx   = order[i];
      cfg_wdata = m[order[i]];
      board.set_column(order[i], m[order[i]]);
    end
    @(negedge clk_i);
    cfg_we = 1'b0;
    @(negedge clk_i);
    phases++;
  endtask

  function automatic volume_t box_of(int x0, int y0, int z0, int x1, int y1, int z1);
    volume_t v;
    v = '0;
    v.mode  = MODE_BOX;
    v.pos_x = x0[COORD_WIDTH-1:0]; v.pos_y = y0[COORD_WIDTH-1:0]; v.pos_z = z0[COORD_WIDTH-1:0];
    v.far_x = x1[COORD_WIDTH-1:0]; v.far_y = y1[COORD_WIDTH-1:0]; v.far_z = z1[COORD_WIDTH-1:0];
    return v;
  endfunction

  function automatic volume_t sphere_of(int x, int y, int z, int r);
    volume_t v;
    v = '0;
    v.mode   = MODE_SPHERE;
    v.pos_x  = x[COORD_WIDTH-1:0]; v.pos_y = y[COORD_WIDTH-1:0]; v.pos_z = z[COORD_WIDTH-1:0];
    v.radius = r[COORD_WIDTH-2:0];
    return v;
  endfunction

  function automatic matrix_t fill_matrix(logic [15:0] w_row, logic [15:0] others);
    matrix_t m;
    for (int c = 0; c < 4; c++) m[c] = {w_row, others, others, others};
    return m;
  endfunction

  // diagonal scale, plus small shear and translation if jitter; w row is (0, 0, 0, 1.0)
  function automatic matrix_t scaled_matrix(int scale, bit jitter);
    matrix_t m;
    int      j;
    m = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        j = jitter ? int'($urandom_range(0, scale / 4)) - scale / 8 : 0;
        m[c][r*16 +: 16] = (r == c) ? 16'(scale) : 16'(j);
      end
    end
    for (int r = 0; r < 3; r++) begin
      j = jitter ? int'($urandom_range(0, 16'h800)) - 16'h400 : 0;
      m[3][r*16 +: 16] = 16'(j);
    end
    m[3][48 +: 16] = 16'h1000;
    return m;
  endfunction

  // volumes near the frustum edge, raw noise for noise_pct percent, some swapped boxes
  function automatic volume_t make_volume(int bound, int noise_pct);
    volume_t v;
    int      ctr [3];
    int      ext [3];
    int      lo [3];
    int      hi [3];
    int      kind;
    int      ax;
    int      t;
    v = VOL_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    v.mode = $urandom_range(0, 1) ? MODE_SPHERE : MODE_BOX;
    kind = $urandom_range(0, 99);
    if (kind < noise_pct) return v;
    for (int a = 0; a < 3; a++) begin
      ctr[a] = int'($urandom_range(0, 6 * bound)) - 3 * bound;
      ext[a] = $urandom_range(0, bound);
      lo[a]  = ctr[a] - ext[a];
      hi[a]  = ctr[a] + ext[a];
    end
    if (kind < noise_pct + 8) begin
      ax = $urandom_range(0, 2);
      t = lo[ax]; lo[ax] = hi[ax]; hi[ax] = t;
    end
    v.pos_x = ctr[0][COORD_WIDTH-1:0];
    v.pos_y = ctr[1][COORD_WIDTH-1:0];
    v.pos_z = ctr[2][COORD_WIDTH-1:0];
    v.radius = ext[$urandom_range(0, 2)][COORD_WIDTH-2:0];
    if (v.mode == MODE_BOX) begin
      v.pos_x = lo[0][COORD_WIDTH-1:0]; v.far_x = hi[0][COORD_WIDTH-1:0];
      v.pos_y = lo[1][COORD_WIDTH-1:0]; v.far_y = hi[1][COORD_WIDTH-1:0];
      v.pos_z = lo[2][COORD_WIDTH-1:0]; v.far_z = hi[2][COORD_WIDTH-1:0];
    end
    return v;
  endfunction

  task automatic send_extremes();
    send_volume(box_of(-8388608, -8388608, -8388608, -8388608, -8388608, -8388608));
    send_volume(box_of(8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    send_volume(sphere_of(8388607, 8388607, 8388607, 8388607));
    send_volume(sphere_of(-8388608, -8388608, -8388608, 8388607));
  endtask

  task automatic run_phase(input matrix_t m, input int count, input int bound,
                           input int noise_pct, input bit pause_midway);
    wait_quiet();
    load_matrix(m);
    send_eager = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if (pause_midway && i == count / 2) wait_quiet();
      send_volume(make_volume(bound, noise_pct));
    end
  endtask

  initial begin : stimulus
    int scale;
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = MAT_COL0;
    cfg_wdata  = '0;
    s_valid    = 1'b0;
    s_data     = '0;
    s_user     = MODE_BOX;
    send_eager = 1'b0;
    phases     = 0;
    repeat (11) @(negedge clk_i);
    rst_n = 1'b1;

    // planes all zero after reset: everything passes
    send_extremes();
    send_volume(box_of(8388607, 8388607, 8388607, -8388608, -8388608, -8388608));

    // unit cube frustum: touching faces, one past them, swapped corners, spheres
    wait_quiet();
    load_matrix(scaled_matrix(16'h1000, 1'b0));
    send_volume(box_of(-300, -100, -100, -256, 100, 100));
    send_volume(box_of(-300, -100, -100, -257, 100, 100));
    send_volume(box_of(256, -100, -100, 300, 100, 100));
    send_volume(box_of(257, -100, -100, 300, 100, 100));
    send_volume(box_of(-100, 300, -100, 100, 400, 100));
    send_volume(box_of(-100, -100, -500, 100, 100, -257));
    send_volume(box_of(300, 0, 0, -300, 0, 0));
    send_volume(box_of(100, 100, 100, -100, -100, -100));
    send_volume(sphere_of(-512, 0, 0, 256));
    send_volume(sphere_of(-512, 0, 0, 255));
    send_volume(sphere_of(0, 0, 600, 343));
    send_volume(sphere_of(0, 0, 600, 344));

    // coefficient extremes
    wait_quiet();
    load_matrix(fill_matrix(16'h7fff, 16'h7fff));
    send_extremes();
    for (int i = 0; i < 20; i++) send_volume(make_volume(0, 100));
    wait_quiet();
    load_matrix(fill_matrix(16'h8000, 16'h8000));
    send_extremes();
    for (int i = 0; i < 20; i++) send_volume(make_volume(0, 100));
    run_phase(fill_matrix(16'h7fff, 16'h8000), 20, 0, 100, 1'b0);
    run_phase(fill_matrix(16'h8000, 16'h7fff), 20, 0, 100, 1'b0);
    run_phase(fill_matrix(16'hffff, 16'hffff), 20, 0, 100, 1'b0);
    run_phase(fill_matrix(16'h0000, 16'h0000), 10, 0, 100, 1'b0);

    // random frustums with volumes spread around their faces
    for (int p = 0; p < 9; p++) begin
      case (p)
        0:       scale = 1;
        1:       scale = 16'h4000;
        default: scale = $urandom_range(16, 16'h2000);
      endcase
      run_phase(scaled_matrix(scale, 1'b1), 120, (1 << 20) / scale, 12, p == 3);
    end
    run_phase({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom}, 150, 0, 100, 1'b0);

    wait_quiet();
    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: %0d visible flags never arrived", $time, board.pending());
    end
    $display("%0d boxes and %0d spheres over %0d matrix settings, %0d visible, %0d culled",
             board.boxes, board.spheres, phases, board.shown, board.culled);
    if (board.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
